[rtl/core/staggered_depth_derivative_assert.svh]
// ----------------------------------------------------------------------------
// Staggered depth derivative assertion macros
// Shared concurrent assertion forms for the derivative core.
// ----------------------------------------------------------------------------
`ifndef STAGGERED_DEPTH_DERIVATIVE_ASSERT_SVH
`define STAGGERED_DEPTH_DERIVATIVE_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define SDD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define SDD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/sdd_pkg.sv]
// ----------------------------------------------------------------------------
// sdd_pkg
// Types and constants shared by the staggered depth derivative core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdd_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int DIFF_W     = 33;
   localparam int X_W        = 39;
   localparam int DERIV_W    = 42;
   localparam int ROW_IDX_W  = 12;
   localparam int CSR_W      = 13;
   localparam int CSR_ADDR_W = 2;
   localparam int RSP_DATA_W = 56;

   localparam int DEF_MAX_COLUMN_LENGTH = 4096;
   localparam int DEF_MAX_COLUMNS       = 4096;
   localparam int MIN_COLUMN_LENGTH     = 4;

   localparam logic [CSR_W-1:0] RST_COLUMN_LENGTH = 13'd4096;
   localparam logic [CSR_W-1:0] RST_COLUMN_COUNT  = 13'd4096;

   // Divide by three, one byte per cell: floor(v / 3) = (v * 683) >> 11 for v < 768
   localparam int DIV_CELLS   = 6;
   localparam int DIV_W       = 8 * DIV_CELLS;
   localparam int DIV_DIGIT_W = 8;
   localparam int DIV_CUR_W   = DIV_DIGIT_W + 2;
   localparam int DIV_PROD_W  = 20;
   localparam int DIV3_RECIP  = 683;
   localparam int DIV3_SHIFT  = 11;

   localparam int QUEUE_DEPTH = 16;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_COLUMN_LENGTH   = 2'd0,
      CSR_COLUMN_COUNT    = 2'd1,
      CSR_STAGGER_FORWARD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CSR_W-1:0] column_length;
      logic [CSR_W-1:0] column_count;
      logic             stagger_forward;
   } cfg_type;

   typedef struct packed {
      logic                      int_vld;
      logic                      edge_vld;
      logic                      neg;
      logic signed [DERIV_W-1:0] edge_val;
      logic [ROW_IDX_W-1:0]      int_row;
      logic [ROW_IDX_W-1:0]      edge_row;
      logic                      last_col;
      logic                      last_frame;
   } tag_type;

   typedef struct packed {
      logic signed [DERIV_W-1:0] derivative;
      logic [ROW_IDX_W-1:0]      row_index;
      logic                      last_in_column;
      logic                      last_in_frame;
   } result_type;

endpackage

[rtl/core/sdd_front.sv]
// ----------------------------------------------------------------------------
// sdd_front
// Sample line, row/column tracking, differences and the 27*d1 - d2 stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "staggered_depth_derivative_assert.svh"

module sdd_front #(
   parameter int MAX_COLUMN_LENGTH = sdd_pkg::DEF_MAX_COLUMN_LENGTH,
   parameter int MAX_COLUMNS       = sdd_pkg::DEF_MAX_COLUMNS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sdd_pkg::cfg_type                    cfg,
   input  logic                                fire,
   input  logic signed [sdd_pkg::SAMPLE_W-1:0] sample,
   output logic [1:0]                          n_results,
   output logic                                div_vld,
   output logic [sdd_pkg::DIV_W-1:0]           div_num,
   output sdd_pkg::tag_type                    div_tag
);

   localparam int ROW_W = $clog2(MAX_COLUMN_LENGTH);
   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int LEN_W = ($clog2(MAX_COLUMN_LENGTH + 1) > sdd_pkg::CSR_W) ?
                          $clog2(MAX_COLUMN_LENGTH + 1) : sdd_pkg::CSR_W;
   localparam int CNT_W = ($clog2(MAX_COLUMNS + 1) > sdd_pkg::CSR_W) ?
                          $clog2(MAX_COLUMNS + 1) : sdd_pkg::CSR_W;

   logic signed [sdd_pkg::SAMPLE_W-1:0] smp_ff [3];
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   logic [LEN_W-1:0] len_raw, len_eff;
   logic [CNT_W-1:0] cnt_raw, cnt_eff;
   logic             last_col, col_last, is_r1, is_int;

   logic signed [sdd_pkg::DIFF_W-1:0] d1_ff, d1_in, d2_ff, d2_in, de;
   logic signed [sdd_pkg::X_W-1:0]    x_ff, x_in;
   logic [sdd_pkg::X_W-1:0]           mag;
   logic [sdd_pkg::DIV_W-1:0]         num_ff, num_in;
   sdd_pkg::tag_type                  tag1_ff, tag1_in, tag2_ff, tag3_ff, tag3_in;
   logic                              v1_ff, v2_ff, v3_ff;

   // Clamp the registers to their legal ranges
   always_comb begin
      len_raw = LEN_W'(cfg.column_length);
      cnt_raw = CNT_W'(cfg.column_count);
      if (len_raw < LEN_W'(sdd_pkg::MIN_COLUMN_LENGTH)) begin
         len_eff = LEN_W'(sdd_pkg::MIN_COLUMN_LENGTH);
      end else if (len_raw > LEN_W'(MAX_COLUMN_LENGTH)) begin
         len_eff = LEN_W'(MAX_COLUMN_LENGTH);
      end else begin
         len_eff = len_raw;
      end
      if (cnt_raw == '0) begin
         cnt_eff = CNT_W'(1);
      end else if (cnt_raw > CNT_W'(MAX_COLUMNS)) begin
         cnt_eff = CNT_W'(MAX_COLUMNS);
      end else begin
         cnt_eff = cnt_raw;
      end
   end

   always_comb begin
      last_col  = LEN_W'(row_ff) >= (len_eff - LEN_W'(1));
      col_last  = CNT_W'(col_ff) >= (cnt_eff - CNT_W'(1));
      is_r1     = row_ff == ROW_W'(1);
      is_int    = row_ff >= ROW_W'(3);
      n_results = 2'(is_r1) + 2'(is_int) + 2'(last_col);

      de    = sdd_pkg::DIFF_W'(sample) - sdd_pkg::DIFF_W'(smp_ff[0]);
      d1_in = sdd_pkg::DIFF_W'(smp_ff[0]) - sdd_pkg::DIFF_W'(smp_ff[1]);
      d2_in = sdd_pkg::DIFF_W'(sample) - sdd_pkg::DIFF_W'(smp_ff[2]);

      tag1_in            = '0;
      tag1_in.int_vld    = is_int;
      tag1_in.edge_vld   = is_r1 | last_col;
      tag1_in.edge_val   = {de[sdd_pkg::DIFF_W-1], de, 8'h00};
      tag1_in.int_row    = sdd_pkg::ROW_IDX_W'(ROW_W'(row_ff - ROW_W'(1)
                                                      - ROW_W'(cfg.stagger_forward)));
      tag1_in.edge_row   = is_r1 ?
                           sdd_pkg::ROW_IDX_W'(ROW_W'(ROW_W'(1) - ROW_W'(cfg.stagger_forward))) :
                           sdd_pkg::ROW_IDX_W'(ROW_W'(row_ff - ROW_W'(cfg.stagger_forward)));
      tag1_in.last_col   = last_col;
      tag1_in.last_frame = last_col & col_last;

      if (last_col) begin
         row_in = '0;
         col_in = col_last ? '0 : COL_W'(col_ff + COL_W'(1));
      end else begin
         row_in = ROW_W'(row_ff + ROW_W'(1));
         col_in = col_ff;
      end
   end

   always_comb begin
      x_in = (sdd_pkg::X_W'(d1_ff) * sdd_pkg::X_W'(27)) - sdd_pkg::X_W'(d2_ff);
      mag  = x_ff[sdd_pkg::X_W-1] ? (~x_ff + sdd_pkg::X_W'(1)) : x_ff;
      // 32*|x| + 1 is the rounded dividend; low five bits of 32*|x| are zero
      num_in      = sdd_pkg::DIV_W'({mag, 5'b00001});
      tag3_in     = tag2_ff;
      tag3_in.neg = x_ff[sdd_pkg::X_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         if (fire) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         v1_ff <= fire;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         smp_ff[0] <= sample;
         smp_ff[1] <= smp_ff[0];
         smp_ff[2] <= smp_ff[1];
      end
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      tag1_ff <= tag1_in;
      x_ff    <= x_in;
      tag2_ff <= tag1_ff;
      num_ff  <= num_in;
      tag3_ff <= tag3_in;
   end

   assign div_vld = v3_ff;
   assign div_num = num_ff;
   assign div_tag = tag3_ff;

   `SDD_ASSERT_IMPL(a_last_has_interior, clock, reset, fire && last_col, is_int, "column end without interior result")
   `SDD_ASSERT_NEXT(a_row_restart, clock, reset, fire && last_col, row_ff == '0, "row did not restart after column end")

endmodule

[rtl/core/sdd_div_cell.sv]
// ----------------------------------------------------------------------------
// sdd_div_cell
// One byte of the divide-by-three chain; remainder and payload pass on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "staggered_depth_derivative_assert.svh"

module sdd_div_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      vld_in,
   input  logic [1:0]                rem_in,
   input  logic [sdd_pkg::DIV_W-1:0] num_in,
   input  logic [sdd_pkg::DIV_W-1:0] quo_in,
   input  sdd_pkg::tag_type          tag_in,
   output logic                      vld_out,
   output logic [1:0]                rem_out,
   output logic [sdd_pkg::DIV_W-1:0] num_out,
   output logic [sdd_pkg::DIV_W-1:0] quo_out,
   output sdd_pkg::tag_type          tag_out
);

   localparam int DW = sdd_pkg::DIV_DIGIT_W;

   logic [sdd_pkg::DIV_CUR_W-1:0]  cur, rem_full;
   logic [sdd_pkg::DIV_PROD_W-1:0] prod;
   logic [DW-1:0]                  qd;

   logic                      vld_ff;
   logic [1:0]                rem_ff, rem_in_next;
   logic [sdd_pkg::DIV_W-1:0] num_ff, num_nx, quo_ff, quo_nx;
   sdd_pkg::tag_type          tag_ff;

   always_comb begin
      cur  = {rem_in, num_in[sdd_pkg::DIV_W-1 -: DW]};
      prod = sdd_pkg::DIV_PROD_W'(cur) * sdd_pkg::DIV_PROD_W'(sdd_pkg::DIV3_RECIP);
      qd   = prod[sdd_pkg::DIV3_SHIFT +: DW];
      rem_full = cur - sdd_pkg::DIV_CUR_W'({qd, 1'b0}) - sdd_pkg::DIV_CUR_W'(qd);
      rem_in_next = rem_full[1:0];
      quo_nx = {quo_in[sdd_pkg::DIV_W-DW-1:0], qd};
      num_nx = {num_in[sdd_pkg::DIV_W-DW-1:0], {DW{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in_next;
      num_ff <= num_nx;
      quo_ff <= quo_nx;
      tag_ff <= tag_in;
   end

   assign vld_out = vld_ff;
   assign rem_out = rem_ff;
   assign num_out = num_ff;
   assign quo_out = quo_ff;
   assign tag_out = tag_ff;

   `SDD_ASSERT_IMPL(a_rem_range, clock, reset, vld_ff, rem_ff != 2'd3, "divide remainder out of range")

endmodule

[rtl/core/sdd_out_queue.sv]
// ----------------------------------------------------------------------------
// sdd_out_queue
// Result queue: up to two words in per cycle, one word out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "staggered_depth_derivative_assert.svh"

module sdd_out_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_a,
   input  sdd_pkg::result_type res_a,
   input  logic                push_b,
   input  sdd_pkg::result_type res_b,
   input  logic                pop,
   output logic                not_empty,
   output sdd_pkg::result_type head
);

   localparam int PW = sdd_pkg::QUEUE_PTR_W;
   localparam int CW = sdd_pkg::QUEUE_CNT_W;

   sdd_pkg::result_type mem_ff [sdd_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in, wb_idx;
   logic [CW-1:0] cnt_ff, cnt_in;

   always_comb begin
      wb_idx = PW'(wp_ff + PW'(push_a));
      wp_in  = PW'(wp_ff + PW'(push_a) + PW'(push_b));
      rp_in  = PW'(rp_ff + PW'(pop));
      cnt_in = CW'(cnt_ff + CW'(push_a) + CW'(push_b) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Interior word goes ahead of the edge word of the same sample
   always_ff @(posedge clock) begin
      if (push_a) begin
         mem_ff[wp_ff] <= res_a;
      end
      if (push_b) begin
         mem_ff[wb_idx] <= res_b;
      end
   end

   assign not_empty = cnt_ff != '0;
   assign head      = mem_ff[rp_ff];

   `SDD_ASSERT_ALWAYS(a_q_bound, clock, reset, cnt_ff <= CW'(sdd_pkg::QUEUE_DEPTH), "result queue overflow")
   `SDD_ASSERT_IMPL(a_q_pop_ok, clock, reset, pop, cnt_ff != '0, "pop from empty result queue")

endmodule

[rtl/core/staggered_depth_derivative.sv]
// ----------------------------------------------------------------------------
// staggered_depth_derivative
// Fourth-order staggered-grid depth derivative over column-major samples.
// Throughput: one sample word per cycle while req_tready is high, results drained
// one word per cycle while rsp_tready is high.
// Intake is paced by a 16-word result queue: req_tready drops while results
// accepted but not yet delivered reach 15.
// Reset: synchronous; row/column restart at zero, registers L=4096, C=4096,
// backward stagger.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "staggered_depth_derivative_assert.svh"

module staggered_depth_derivative #(
   parameter int MAX_COLUMN_LENGTH = sdd_pkg::DEF_MAX_COLUMN_LENGTH,
   parameter int MAX_COLUMNS       = sdd_pkg::DEF_MAX_COLUMNS
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [31:0] sample
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sdd_pkg::SAMPLE_W-1:0]      req_tdata,
   // rsp_tdata: [41:0] derivative, [53:42] row_index, [55:54] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sdd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,   // last_in_column
   output logic                              rsp_tuser,   // last_in_frame
   input  logic                              csr_we,
   input  logic [sdd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sdd_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int NC = sdd_pkg::DIV_CELLS;
   localparam int CW = sdd_pkg::QUEUE_CNT_W;

   sdd_pkg::cfg_type cfg_ff;
   logic [CW-1:0]    pend_ff, pend_in;
   logic             fire, pop;
   logic [1:0]       n_results;

   logic                      cell_vld [NC+1];
   logic [1:0]                cell_rem [NC+1];
   logic [sdd_pkg::DIV_W-1:0] cell_num [NC+1];
   logic [sdd_pkg::DIV_W-1:0] cell_quo [NC+1];
   sdd_pkg::tag_type          cell_tag [NC+1];

   logic signed [sdd_pkg::DERIV_W-1:0] quo_s;
   sdd_pkg::result_type res_a, res_b, head;
   logic push_a, push_b;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_length   <= sdd_pkg::RST_COLUMN_LENGTH;
         cfg_ff.column_count    <= sdd_pkg::RST_COLUMN_COUNT;
         cfg_ff.stagger_forward <= 1'b0;
      end else if (csr_we) begin
         case (sdd_pkg::csr_index_type'(csr_addr))
            sdd_pkg::CSR_COLUMN_LENGTH: begin
               cfg_ff.column_length <= csr_wdata;
            end
            sdd_pkg::CSR_COLUMN_COUNT: begin
               cfg_ff.column_count <= csr_wdata;
            end
            sdd_pkg::CSR_STAGGER_FORWARD: begin
               cfg_ff.stagger_forward <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Hold intake while the queue might not fit two more words
   assign req_tready = pend_ff <= CW'(sdd_pkg::QUEUE_DEPTH - 2);
   assign fire       = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;

   always_comb begin
      pend_in = CW'(pend_ff + (fire ? CW'(n_results) : CW'(0)) - CW'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   sdd_front #(
      .MAX_COLUMN_LENGTH (MAX_COLUMN_LENGTH),
      .MAX_COLUMNS       (MAX_COLUMNS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .fire      (fire),
      .sample    ($signed(req_tdata)),
      .n_results (n_results),
      .div_vld   (cell_vld[0]),
      .div_num   (cell_num[0]),
      .div_tag   (cell_tag[0])
   );

   assign cell_rem[0] = 2'd0;
   assign cell_quo[0] = '0;

   for (genvar i = 0; i < NC; i++) begin : g_div
      sdd_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .vld_in  (cell_vld[i]),
         .rem_in  (cell_rem[i]),
         .num_in  (cell_num[i]),
         .quo_in  (cell_quo[i]),
         .tag_in  (cell_tag[i]),
         .vld_out (cell_vld[i+1]),
         .rem_out (cell_rem[i+1]),
         .num_out (cell_num[i+1]),
         .quo_out (cell_quo[i+1]),
         .tag_out (cell_tag[i+1])
      );
   end

   always_comb begin
      quo_s  = $signed(cell_quo[NC][sdd_pkg::DERIV_W-1:0]);
      push_a = cell_vld[NC] & cell_tag[NC].int_vld;
      push_b = cell_vld[NC] & cell_tag[NC].edge_vld;

      res_a.derivative     = cell_tag[NC].neg ? -quo_s : quo_s;
      res_a.row_index      = cell_tag[NC].int_row;
      res_a.last_in_column = 1'b0;
      res_a.last_in_frame  = 1'b0;

      res_b.derivative     = cell_tag[NC].edge_val;
      res_b.row_index      = cell_tag[NC].edge_row;
      res_b.last_in_column = cell_tag[NC].last_col;
      res_b.last_in_frame  = cell_tag[NC].last_frame;
   end

   sdd_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .res_a     (res_a),
      .push_b    (push_b),
      .res_b     (res_b),
      .pop       (pop),
      .not_empty (rsp_tvalid),
      .head      (head)
   );

   assign rsp_tdata = {2'b00, head.row_index, head.derivative};
   assign rsp_tlast = head.last_in_column;
   assign rsp_tuser = head.last_in_frame;

   `SDD_ASSERT_ALWAYS(a_pend_bound, clock, reset, pend_ff <= CW'(sdd_pkg::QUEUE_DEPTH), "pending word count exceeds queue")
   `SDD_ASSERT_IMPL(a_pend_covers_out, clock, reset, rsp_tvalid, pend_ff != '0, "word shown without pending credit")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the staggered depth derivative core. Streams
// column-major samples under random valid/ready gaps and one long output
// stall. Each result word is compared with an in-bench forecast of the
// fourth-order depth derivative, its row label and its column/frame flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import sdd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic {STEP_WRITE, STEP_SAMPLE} step_kind_type;

   typedef struct {
      step_kind_type         kind;
      logic [CSR_ADDR_W-1:0] idx;
      logic [31:0]           value;
      int                    n_fixed;   // -1: take the forecast
      result_type            fixed0;
      result_type            fixed1;
   } step_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_W-1:0]       csr_wdata;

   // forecast state
   cfg_type                cfg;
   logic signed [31:0]     prev_samples [3];
   logic [ROW_IDX_W-1:0]   depth_row;
   logic [ROW_IDX_W-1:0]   column_idx;

   result_type             due_derivatives [$];
   step_type               plan [$];
   int                     mismatches = 0;
   bit                     sender_quiet = 0;
   bit                     receiver_quiet = 0;
   bit                     hold_request = 0;

   staggered_depth_derivative i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("staggered_depth_derivative: mismatch");
      $finish;
   end

   function automatic result_type shape(longint v, int row, logic lc, logic lf);
      result_type res;
      res.derivative     = v[DERIV_W-1:0];
      res.row_index      = ROW_IDX_W'(row);
      res.last_in_column = lc;
      res.last_in_frame  = lf;
      return res;
   endfunction

   // Results that one sample word causes; advances the row/column state.
   function automatic int forecast_derivatives(input logic [31:0] word,
                                               output result_type outs[2]);
      int     len, cnt, r, shift, n;
      logic   last_col, last_frame;
      longint s, p0, p1, p2, d1, d2, x, val;
      len   = cfg.column_length;
      cnt   = cfg.column_count;
      r     = depth_row;
      shift = cfg.stagger_forward;
      s     = longint'($signed(word));
      p0    = longint'(prev_samples[0]);
      p1    = longint'(prev_samples[1]);
      p2    = longint'(prev_samples[2]);
      n     = 0;
      if (len < MIN_COLUMN_LENGTH) len = MIN_COLUMN_LENGTH;
      if (len > DEF_MAX_COLUMN_LENGTH) len = DEF_MAX_COLUMN_LENGTH;
      if (cnt < 1) cnt = 1;
      if (cnt > DEF_MAX_COLUMNS) cnt = DEF_MAX_COLUMNS;
      last_col   = (r >= len - 1);
      last_frame = last_col && (int'(column_idx) >= cnt - 1);
      if (r == 1) begin
         outs[n] = shape((s - p0) * 256, 1 - shift, 1'b0, 1'b0);
         n++;
      end
      if (r >= 3) begin
         d1 = p0 - p1;
         d2 = s - p2;
         x  = (27 * d1 - d2) * 32;
         // round to nearest, symmetric about zero
         if (x >= 0) val = (x + 1) / 3;
         else val = -((-x + 1) / 3);
         outs[n] = shape(val, r - 1 - shift, 1'b0, 1'b0);
         n++;
      end
      if (last_col) begin
         outs[n] = shape((s - p0) * 256, r - shift, 1'b1, last_frame);
         n++;
      end
      prev_samples[2] = prev_samples[1];
      prev_samples[1] = prev_samples[0];
      prev_samples[0] = word;
      if (last_col) begin
         depth_row = '0;
         if (int'(column_idx) >= cnt - 1) column_idx = '0;
         else column_idx = column_idx + 1'b1;
      end else begin
         depth_row = depth_row + 1'b1;
      end
      return n;
   endfunction

   task automatic push_sample(input logic [31:0] word, input int n_fixed,
                              input result_type f0, input result_type f1);
      int         gap;
      int         n;
      result_type outs [2];
      gap = sender_quiet ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      n = forecast_derivatives(word, outs);
      if (n_fixed >= 0) begin
         // hand-computed rows: the forecast only advances state
         n = n_fixed;
         outs[0] = f0;
         outs[1] = f1;
      end
      for (int k = 0; k < n; k++) due_derivatives.push_back(outs[k]);
   endtask

   // Drop valid, drain every pending word, then let the pipeline empty.
   task automatic settle_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_derivatives.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[CSR_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_COLUMN_LENGTH:   cfg.column_length   = value[CSR_W-1:0];
         CSR_COLUMN_COUNT:    cfg.column_count    = value[CSR_W-1:0];
         CSR_STAGGER_FORWARD: cfg.stagger_forward = value[0];
         default: ;
      endcase
   endtask

   // Result receiver: random backpressure, one long hold-off on request.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (int c = 0; c < 300; c++) @(negedge clock);
            hold_request = 0;
         end else begin
            gap = receiver_quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : watch_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_derivatives.size() == 0) begin
            $error("unexpected result word: derivative %0d row %0d",
                   $signed(rsp_tdata[DERIV_W-1:0]), rsp_tdata[DERIV_W +: ROW_IDX_W]);
            mismatches++;
         end else begin
            want = due_derivatives.pop_front();
            if (rsp_tdata[DERIV_W-1:0] !== want.derivative) begin
               $error("derivative: expected %0d, got %0d", want.derivative,
                      $signed(rsp_tdata[DERIV_W-1:0]));
               mismatches++;
            end
            if (rsp_tdata[DERIV_W +: ROW_IDX_W] !== want.row_index) begin
               $error("row_index: expected %0d, got %0d", want.row_index,
                      rsp_tdata[DERIV_W +: ROW_IDX_W]);
               mismatches++;
            end
            if (rsp_tlast !== want.last_in_column) begin
               $error("last_in_column: expected %0b, got %0b", want.last_in_column,
                      rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser !== want.last_in_frame) begin
               $error("last_in_frame: expected %0b, got %0b", want.last_in_frame,
                      rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int          phase;
      int          random_sent;
      int          n;
      int          eff_len;
      logic [31:0] word;
      logic [31:0] value;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      cfg.column_length   = RST_COLUMN_LENGTH;
      cfg.column_count    = RST_COLUMN_COUNT;
      cfg.stagger_forward = 1'b0;
      prev_samples = '{default: '0};
      depth_row  = '0;
      column_idx = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // shortest column, one column per frame, full-scale swings
      plan.push_back('{STEP_WRITE, CSR_COLUMN_LENGTH, 32'd0, -1, '0, '0});
      plan.push_back('{STEP_WRITE, CSR_COLUMN_COUNT, 32'd0, -1, '0, '0});
      plan.push_back('{STEP_WRITE, CSR_STAGGER_FORWARD, 32'd0, -1, '0, '0});
      plan.push_back('{STEP_WRITE, CSR_SPARE, 32'd8191, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h7FFF_FFFF, 0, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h8000_0000, 1,
                       '{-42'sd1099511627520, 12'd1, 1'b0, 1'b0}, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h7FFF_FFFF, 0, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h8000_0000, 2,
                       '{42'sd1282763565440, 12'd2, 1'b0, 1'b0},
                       '{-42'sd1099511627520, 12'd3, 1'b1, 1'b1}});
      // forward stagger relabels rows
      plan.push_back('{STEP_WRITE, CSR_STAGGER_FORWARD, 32'd1, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h0000_0000, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h0001_0000, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'hFFFF_0000, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h0000_3039, -1, '0, '0});
      // length shrinks mid-column: next word closes it
      plan.push_back('{STEP_WRITE, CSR_COLUMN_COUNT, 32'd8191, -1, '0, '0});
      plan.push_back('{STEP_WRITE, CSR_COLUMN_LENGTH, 32'd8, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h0000_0005, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'hFFFF_FFFE, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h0000_0007, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'hFFFF_FFF9, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h0000_0001, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h7FFF_0000, -1, '0, '0});
      plan.push_back('{STEP_WRITE, CSR_COLUMN_LENGTH, 32'd4, -1, '0, '0});
      plan.push_back('{STEP_SAMPLE, '0, 32'h8000_0001, -1, '0, '0});

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_WRITE) begin
            settle_block();
            write_csr(plan[i].idx, plan[i].value);
         end else begin
            push_sample(plan[i].value, plan[i].n_fixed, plan[i].fixed0, plan[i].fixed1);
         end
      end

      phase = 0;
      random_sent = 0;
      while (random_sent < 800) begin
         settle_block();
         sender_quiet   = ($urandom_range(0, 3) == 0);
         receiver_quiet = ($urandom_range(0, 3) == 0);
         if (phase == 6) begin
            // one long column, well past the short ones
            write_csr(CSR_COLUMN_LENGTH, 32'd200);
            write_csr(CSR_COLUMN_COUNT, $urandom_range(1, 3));
         end else begin
            if ($urandom_range(0, 1)) begin
               case ($urandom_range(0, 9))
                  0: case ($urandom_range(0, 6))
                        0: value = 0;
                        1: value = 1;
                        2: value = 2;
                        3: value = 3;
                        4: value = 4;
                        5: value = 4096;
                        default: value = 8191;
                     endcase
                  1: value = $urandom_range(0, 8191);
                  default: value = $urandom_range(4, 12);
               endcase
               write_csr(CSR_COLUMN_LENGTH, value);
            end
            if ($urandom_range(0, 1)) begin
               case ($urandom_range(0, 4))
                  0: case ($urandom_range(0, 4))
                        0: value = 0;
                        1: value = 1;
                        2: value = 4096;
                        3: value = 8191;
                        default: value = $urandom_range(0, 8191);
                     endcase
                  default: value = $urandom_range(1, 4);
               endcase
               write_csr(CSR_COLUMN_COUNT, value);
            end
            if ($urandom_range(0, 1)) write_csr(CSR_STAGGER_FORWARD, $urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0) write_csr(CSR_SPARE, $urandom);
         end

         eff_len = cfg.column_length;
         if (eff_len < MIN_COLUMN_LENGTH) eff_len = MIN_COLUMN_LENGTH;
         if (eff_len > DEF_MAX_COLUMN_LENGTH) eff_len = DEF_MAX_COLUMN_LENGTH;
         if (phase == 6) n = 200 + $urandom_range(0, 8);
         else if (eff_len <= 64) begin
            n = eff_len * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(0, eff_len - 1);
         end else n = $urandom_range(1, 40);

         if (phase == 3) begin
            // hold the receiver off while words keep coming
            sender_quiet = 1;
            hold_request = 1;
            if (n < 64) n = 64;
         end

         repeat (n) begin
            case ($urandom_range(0, 7))
               0: case ($urandom_range(0, 3))
                     0: word = 32'h7FFF_FFFF;
                     1: word = 32'h8000_0000;
                     2: word = 32'h0000_0000;
                     default: word = 32'hFFFF_FFFF;
                  endcase
               1, 2: word = 32'($urandom_range(0, 4095)) - 32'd2048;
               default: word = $urandom;
            endcase
            push_sample(word, -1, '0, '0);
            random_sent++;
         end
         phase++;
      end

      settle_block();
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("staggered_depth_derivative: match");
      end else begin
         $display("staggered_depth_derivative: mismatch");
      end
      $finish;
   end

endmodule
